// File: design/afur_pkg.sv
// Shared types and constants for the audio FIFO with underrun frame repeat.
// Used by audio_fifo_underrun_repeat_top and its testbench; no dependencies.
package afur_pkg;

   localparam int FIFO_DEPTH = 4096;
   localparam int MAX_FRAME  = 8;

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int POS_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int FS_W   = $clog2(MAX_FRAME + 1);
   localparam int CFG_W  = 4;
   localparam int BYTE_W = 8;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = CFG_W'(4);

   // register index, taken from paddr[ADDR_W-1:2]
   localparam logic [ADDR_W-3:0] REG_FRAME_SIZE = '0;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [1:0] {
      STAT_STORED  = 2'd0,
      STAT_DROPPED = 2'd1,
      STAT_BUFFER  = 2'd2,
      STAT_REPEAT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUFFER,
      ST_REPEAT
   } state_type;

   // frame size as used: zero acts as one, above MAX_FRAME clamps
   function automatic logic [FS_W-1:0] eff_frame_size(input logic [CFG_W-1:0] cfg);
      logic [7:0] v;
      v = {4'b0, cfg};
      if (v == 8'd0) v = 8'd1;
      if (v > 8'(MAX_FRAME)) v = 8'(MAX_FRAME);
      return v[FS_W-1:0];
   endfunction

endpackage

// File: design/afur_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies; data holds while rd_en is low.
module afur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/audio_fifo_underrun_repeat_top.sv
// Audio byte FIFO with frame commit and last-frame repeat on underrun.
// Depends on afur_pkg and afur_ram (sample ring).
//
// Usage:
//  - req channel: req_kind selects write (one byte) or read (one frame).
//  - rsp channel: a write gives one item (status stored or dropped, frame_end
//    set); a read gives frame_size items (zero as one, capped at MAX_FRAME),
//    the last with frame_end set, with status buffer (bytes from the ring)
//    or repeat (last committed frame).
//  - APB port: register 0 is frame_size (reset 4), to be written only while
//    idle; the block itself does not enforce this.
// Timing:
//  - write: the result sits in the output register the next cycle.
//  - read: one byte per cycle while the output is not stalled, from the ring
//    (single read port, first read in the accept cycle) or the repeat store.
// Reset clears pointers, counts and the last-frame store (zeros); the ring
// needs no clearing pass. While rsp_valid and rsp_stall are high the output
// register holds, reads wait behind one prefetched byte, no item is accepted.
module audio_fifo_underrun_repeat_top
   import afur_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [7:0]        req_data_byte,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_frame_end,
   output logic [1:0]        rsp_status,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  frame_size_ff, frame_size_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [CNT_W-1:0]  committed_ff, committed_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] staging_ff [MAX_FRAME];
   logic [BYTE_W-1:0] staging_in [MAX_FRAME];
   logic [BYTE_W-1:0] last_ff [MAX_FRAME];
   logic [BYTE_W-1:0] last_in [MAX_FRAME];

   logic [FS_W-1:0]   iss_cnt_ff, iss_cnt_in;
   logic [FS_W-1:0]   out_cnt_ff, out_cnt_in;
   logic [POS_W-1:0]  rep_idx_ff, rep_idx_in;
   logic              pend_ff, pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_end_ff, rsp_end_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              rsp_free, accept, accept_wr, accept_rd;
   logic              full, serve, commit, issue, load_buf, load_rep, last_out;
   logic              cfg_wr;
   logic [FS_W-1:0]   fs;
   logic [FS_W-1:0]   pos_inc;
   logic [BYTE_W-1:0] ram_rdata;

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready &&
                   (paddr[ADDR_W-1:2] == REG_FRAME_SIZE);
   assign prdata = (paddr[ADDR_W-1:2] == REG_FRAME_SIZE) ?
                   DATA_W'(frame_size_ff) : '0;
   assign frame_size_in = cfg_wr ? pwdata[CFG_W-1:0] : frame_size_ff;

   // ---------------- handshake and decode ----------------
   assign fs        = eff_frame_size(frame_size_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign accept_wr = accept && (req_kind == KIND_WRITE);
   assign accept_rd = accept && (req_kind == KIND_READ);
   assign full      = (stored_ff == CNT_W'(FIFO_DEPTH));
   assign serve     = (committed_ff >= CNT_W'(fs));
   assign pos_inc   = FS_W'(pos_ff) + FS_W'(1);
   assign commit    = accept_wr && !full && (pos_inc >= fs);
   assign last_out  = (out_cnt_ff == FS_W'(1));

   // ring read: first one in the accept cycle, then one whenever no byte is
   // prefetched or the prefetched byte is moving into the output register
   assign issue    = (accept_rd && serve) ||
                     ((state_ff == ST_BUFFER) && (iss_cnt_ff != '0) &&
                      (!pend_ff || rsp_free));
   assign load_buf = (state_ff == ST_BUFFER) && pend_ff && rsp_free;
   assign load_rep = (state_ff == ST_REPEAT) && rsp_free;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_rd) state_in = serve ? ST_BUFFER : ST_REPEAT;
         end
         ST_BUFFER: begin
            if (load_buf && last_out) state_in = ST_IDLE;
         end
         ST_REPEAT: begin
            if (load_rep && last_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      stored_in    = stored_ff;
      committed_in = committed_ff;
      pos_in       = pos_ff;
      staging_in   = staging_ff;
      last_in      = last_ff;
      iss_cnt_in   = iss_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      rep_idx_in   = rep_idx_ff;
      pend_in      = pend_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;

      if (accept_wr) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = '0;
         rsp_end_in   = 1'b1;
         if (full) begin
            rsp_status_in = STAT_DROPPED;
         end else begin
            rsp_status_in      = STAT_STORED;
            wp_in              = (wp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
            stored_in          = stored_ff + CNT_W'(1);
            staging_in[pos_ff] = req_data_byte;
            if (commit) begin
               for (int i = 0; i < MAX_FRAME; i++) begin
                  if (FS_W'(i) < pos_inc) begin
                     last_in[i] = (POS_W'(i) == pos_ff) ? req_data_byte : staging_ff[i];
                  end
               end
               committed_in = committed_ff + CNT_W'(pos_inc);
               pos_in       = '0;
            end else begin
               pos_in = pos_inc[POS_W-1:0];
            end
         end
      end

      if (accept_rd) begin
         out_cnt_in = fs;
         rep_idx_in = '0;
         if (serve) begin
            committed_in = committed_ff - CNT_W'(fs);
            stored_in    = stored_ff - CNT_W'(fs);
            iss_cnt_in   = fs - FS_W'(1);
         end
      end

      if (issue) begin
         rp_in = (rp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
         if (!accept_rd) iss_cnt_in = iss_cnt_ff - FS_W'(1);
         pend_in = 1'b1;
      end else if (load_buf) begin
         pend_in = 1'b0;
      end

      if (load_buf || load_rep) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = load_buf ? ram_rdata : last_ff[rep_idx_ff];
         rsp_end_in    = last_out;
         rsp_status_in = load_buf ? STAT_BUFFER : STAT_REPEAT;
         out_cnt_in    = out_cnt_ff - FS_W'(1);
         rep_idx_in    = rep_idx_ff + POS_W'(1);
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frame_size_ff <= FRAME_SIZE_RESET;
         rp_ff         <= '0;
         wp_ff         <= '0;
         stored_ff     <= '0;
         committed_ff  <= '0;
         pos_ff        <= '0;
         iss_cnt_ff    <= '0;
         out_cnt_ff    <= '0;
         rep_idx_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_FRAME; i++) last_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         frame_size_ff <= frame_size_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         stored_ff     <= stored_in;
         committed_ff  <= committed_in;
         pos_ff        <= pos_in;
         iss_cnt_ff    <= iss_cnt_in;
         out_cnt_ff    <= out_cnt_in;
         rep_idx_ff    <= rep_idx_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      staging_ff    <= staging_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ---------------- sample ring ----------------
   afur_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept_wr && !full),
      .wr_addr (wp_ff),
      .wr_data (req_data_byte),
      .rd_en   (issue),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;

   // ---------------- assertions ----------------
   a_commit_le_stored: assert property (@(posedge clock) disable iff (reset)
      committed_ff <= stored_ff)
      else $error("committed count exceeds stored count");

   a_stored_le_depth: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(FIFO_DEPTH))
      else $error("stored count beyond ring depth");

   a_pend_in_buffer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUFFER) |-> (out_cnt_ff == iss_cnt_ff + FS_W'(pend_ff)))
      else $error("ring reads out of step with delivered bytes");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("item accepted while a frame is in flight");

   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept_wr && full) |=> (stored_ff == $past(stored_ff) && wp_ff == $past(wp_ff)))
      else $error("dropped write changed the ring");

endmodule

// File: sim/audio_fifo_underrun_repeat_top_tb.sv
// Self-checking testbench for audio_fifo_underrun_repeat_top: frame commit, buffer reads,
// last-frame repeat on underrun and frame_size changes over APB.
// Depends on afur_pkg and the design files; needs no input files.
module audio_fifo_underrun_repeat_top_tb
   import afur_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 200;

   typedef struct {
      logic        kind;
      logic [7:0]  data;
      int unsigned idle;
   } req_op_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       frame_end;
      status_type status;
   } frame_byte_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = KIND_WRITE;
   logic [7:0]        req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [7:0]        rsp_out_byte;
   logic              rsp_frame_end;
   logic [1:0]        rsp_status;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   audio_fifo_underrun_repeat_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_frame_end(rsp_frame_end),
      .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [7:0]  ring_mem [FIFO_DEPTH];
   logic [7:0]  staging [MAX_FRAME];
   logic [7:0]  prev_frame [MAX_FRAME];
   int unsigned m_rd = 0, m_wr = 0, m_stored = 0, m_committed = 0, m_pos = 0;
   logic [3:0]  cfg_frame_size = FRAME_SIZE_RESET;

   req_op_type     pending_ops [$];
   frame_byte_type frame_bytes_due [$];
   req_op_type     cur_op;
   frame_byte_type due;

   int          items_queued = 0, items_taken = 0, idle_cycles = 0;
   int unsigned wait_cnt = 0, stall_cnt = 0, hold_cnt = 0;
   bit          offering = 0, req_took = 0, rsp_took = 0, activity;
   bit          no_idle = 0, hold_request = 0, failed = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < MAX_FRAME; i++) prev_frame[i] = '0;
   end

   // zero acts as one, anything above MAX_FRAME clamps
   function automatic int unsigned frame_len();
      if (cfg_frame_size == 4'd0) return 1;
      if (cfg_frame_size > MAX_FRAME) return MAX_FRAME;
      return cfg_frame_size;
   endfunction

   function automatic void model_step(input logic kind, input logic [7:0] data);
      int unsigned fs, n, i;
      frame_byte_type r;
      fs = frame_len();
      if (kind == KIND_WRITE) begin
         r.out_byte = '0;
         r.frame_end = 1'b1;
         if (m_stored >= FIFO_DEPTH) begin
            r.status = STAT_DROPPED;
         end else begin
            ring_mem[m_wr] = data;
            m_wr = (m_wr + 1) % FIFO_DEPTH;
            m_stored++;
            if (m_pos < MAX_FRAME) staging[m_pos] = data;
            m_pos++;
            if (m_pos >= fs) begin
               n = (m_pos > MAX_FRAME) ? MAX_FRAME : m_pos;
               for (i = 0; i < n; i++) prev_frame[i] = staging[i];
               m_committed += m_pos;
               m_pos = 0;
            end
            r.status = STAT_STORED;
         end
         frame_bytes_due.push_back(r);
      end else if (m_committed >= fs) begin
         for (i = 0; i < fs; i++) begin
            r.out_byte = ring_mem[m_rd];
            r.frame_end = (i + 1 == fs);
            r.status = STAT_BUFFER;
            frame_bytes_due.push_back(r);
            m_rd = (m_rd + 1) % FIFO_DEPTH;
         end
         m_committed -= fs;
         m_stored -= fs;
      end else begin
         for (i = 0; i < fs; i++) begin
            r.out_byte = prev_frame[i];
            r.frame_end = (i + 1 == fs);
            r.status = STAT_REPEAT;
            frame_bytes_due.push_back(r);
         end
      end
   endfunction

   // acceptance, prediction, checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         activity = 0;
         if (req_valid && !req_stall) begin
            model_step(req_kind, req_data_byte);
            items_taken++;
            req_took = 1;
            activity = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_took = 1;
            activity = 1;
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected result: out_byte %0d frame_end %0d status %0d",
                      rsp_out_byte, rsp_frame_end, rsp_status);
               failed = 1;
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_out_byte !== due.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", due.out_byte, rsp_out_byte);
                  failed = 1;
               end
               if (rsp_frame_end !== due.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", due.frame_end, rsp_frame_end);
                  failed = 1;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  failed = 1;
               end
            end
         end
         idle_cycles = activity ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (req_took) begin
         offering = 0;
         req_took = 0;
      end
      if (!offering && pending_ops.size() > 0) begin
         if (wait_cnt < pending_ops[0].idle) begin
            wait_cnt++;
         end else begin
            cur_op = pending_ops.pop_front();
            offering = 1;
            wait_cnt = 0;
         end
      end
      req_valid <= offering;
      if (offering) begin
         req_kind <= cur_op.kind;
         req_data_byte <= cur_op.data;
      end
   end

   // result side stall, with one long hold-off on request
   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_took = 0;
         stall_cnt = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (hold_request) begin
         hold_request = 0;
         hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_item(input logic kind, input logic [7:0] data);
      req_op_type op;
      op.kind = kind;
      op.data = data;
      op.idle = no_idle ? 0 : $urandom_range(0, 5);
      pending_ops.push_back(op);
      items_queued++;
   endtask

   task automatic wait_idle();
      while (items_taken != items_queued || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [3:0] value);
      wait_idle();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({REG_FRAME_SIZE, 2'b00});
      pwdata <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cfg_frame_size = value;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[3:0] !== value) begin
         $error("frame_size readback: expected %0d, got %0d", value, prdata[3:0]);
         failed = 1;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // mostly whole frames followed by reads, some stray items and partial frames
   task automatic queue_random(input int n);
      int count, k, j, pick;
      int unsigned fs;
      count = 0;
      fs = frame_len();
      while (count < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            k = $urandom_range(1, 3) * fs;
            j = $urandom_range(1, 3);
            repeat (k) queue_item(KIND_WRITE, 8'($urandom_range(0, 255)));
            repeat (j) queue_item(KIND_READ, 8'($urandom_range(0, 255)));
            count += k + j;
         end else if (pick < 9) begin
            queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            count++;
         end else begin
            k = $urandom_range(1, fs);
            repeat (k) queue_item(KIND_WRITE, 8'($urandom_range(0, 255)));
            count += k;
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed: underrun before any frame, buffer read, repeat, partial frame
      queue_item(KIND_READ, 8'hFF);
      queue_item(KIND_WRITE, 8'h00);
      queue_item(KIND_WRITE, 8'hFF);
      queue_item(KIND_WRITE, 8'h55);
      queue_item(KIND_WRITE, 8'hAA);
      queue_item(KIND_READ, 8'h00);
      queue_item(KIND_READ, 8'h00);
      queue_item(KIND_WRITE, 8'h01);
      queue_item(KIND_WRITE, 8'h80);
      queue_item(KIND_WRITE, 8'h7F);
      queue_item(KIND_READ, 8'h00);
      // shrink the frame mid-frame: next write commits all four bytes
      set_frame_size(4'd2);
      queue_item(KIND_WRITE, 8'h3C);
      repeat (3) queue_item(KIND_READ, 8'h00);
      set_frame_size(4'd3);
      repeat (3) queue_item(KIND_WRITE, 8'($urandom_range(0, 255)));
      // committed bytes below the frame size: underrun, leftover waits
      set_frame_size(4'd5);
      queue_item(KIND_READ, 8'h00);
      repeat (5) queue_item(KIND_WRITE, 8'($urandom_range(0, 255)));
      queue_item(KIND_READ, 8'h00);
      set_frame_size(4'd3);
      queue_item(KIND_READ, 8'h00);

      // random phases over several frame sizes
      set_frame_size(4'd4);
      hold_request = 1;
      queue_random(22);
      set_frame_size(4'd1);
      queue_random(22);
      set_frame_size(4'd8);
      queue_random(22);
      set_frame_size(4'd0);
      queue_random(22);
      set_frame_size(4'd15);
      queue_random(22);
      set_frame_size(4'd6);
      queue_random(22);
      no_idle = 1;
      set_frame_size(4'd7);
      queue_random(22);
      wait_idle();
      no_idle = 0;

      set_frame_size(4'($urandom_range(0, 15)));
      queue_random(22);

      wait_idle();
      repeat (20) @(posedge clock);
      if (!failed)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
design/afur_pkg.sv
design/afur_ram.sv
design/audio_fifo_underrun_repeat_top.sv
sim/audio_fifo_underrun_repeat_top_tb.sv
